FILE: rtl/pss_pkg.sv
`default_nettype none
package pss_pkg;

    localparam int TABLE_SLOTS_DEF = 32;
    localparam int ADDR_W = 16;
    localparam int CNT_W = 16;
    localparam int SUM_W = 32;
    localparam int AVG_W = 16;
    localparam int SLOT_W = 5;
    localparam int DIV_STEPS = 32;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0] cnt;
        logic signed [SUM_W-1:0] sum;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_HIT,
        ST_REC_END,
        ST_EMPTY,
        ST_REP_RD,
        ST_REP_DIV,
        ST_REP_WAIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic idx_init;
        logic idx_inc;
        logic mem_rd;
        logic div_start;
        logic load_hit;
        logic load_append;
        logic load_full;
        logic load_empty;
        logic load_report;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic used_one;
        logic is_full;
        logic hit;
        logic idx_last;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/pss_div.sv
`default_nettype none
module pss_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [pss_pkg::SUM_W-1:0] dividend,
    input  wire logic [pss_pkg::CNT_W-1:0] divisor,
    output logic done,
    output logic signed [pss_pkg::AVG_W-1:0] quotient
);

    localparam int SW = pss_pkg::SUM_W;
    localparam int CW = pss_pkg::CNT_W;
    localparam int AW = pss_pkg::AVG_W;
    localparam int STW = pss_pkg::DIV_STEP_W;

    logic busy_reg, busy_next;
    logic [STW-1:0] step_reg, step_next;
    logic [CW-1:0] rem_reg;
    logic [SW-1:0] quo_reg;
    logic [CW-1:0] dvs_reg;
    logic neg_reg;

    logic [CW:0] rem_shift;
    logic ge;
    logic [CW-1:0] rem_step;
    logic [SW-1:0] magnitude;

    assign magnitude = dividend[SW-1] ? SW'(-dividend) : dividend;
    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign ge = rem_shift >= {1'b0, dvs_reg};
    assign rem_step = ge ? CW'(rem_shift - {1'b0, dvs_reg}) : rem_shift[CW-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = STW'(step_reg + STW'(1));
            if (step_reg == STW'(pss_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // one quotient bit per cycle, restoring form on the magnitude
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude;
            dvs_reg <= divisor;
            neg_reg <= dividend[SW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[SW-2:0], ge};
        end
    end

    assign done = !busy_reg;

    always_comb
    begin
        priority if (dvs_reg == '0)
        begin
            quotient = '0;
        end
        else if (neg_reg)
        begin
            if (quo_reg >= SW'(32768))
            begin
                quotient = {1'b1, {(AW-1){1'b0}}};
            end
            else
            begin
                quotient = AW'(AW'(0) - quo_reg[AW-1:0]);
            end
        end
        else
        begin
            if (quo_reg > SW'(32767))
            begin
                quotient = {1'b0, {(AW-1){1'b1}}};
            end
            else
            begin
                quotient = quo_reg[AW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pss_dp.sv
`default_nettype none
module pss_dp #(
    parameter int TABLE_SLOTS = pss_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pss_pkg::cmd_t cmd,
    output pss_pkg::sts_t sts,
    input  wire logic [31:0] s_tdata,
    input  wire logic s_tuser,
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [87:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic m_tlast
);

    localparam int UW = $clog2(TABLE_SLOTS + 1);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int AW = pss_pkg::ADDR_W;
    localparam int CW = pss_pkg::CNT_W;
    localparam int SW = pss_pkg::SUM_W;
    localparam int VW = pss_pkg::AVG_W;
    localparam int LW = pss_pkg::SLOT_W;

    pss_pkg::entry_t mem [TABLE_SLOTS];
    pss_pkg::entry_t rd_reg;
    pss_pkg::entry_t wr_data;

    logic [AW-1:0] addr_in_reg;
    logic signed [15:0] delay_in_reg;
    logic func_reg;
    logic [UW-1:0] idx_reg, idx_next;
    logic [UW-1:0] used_reg, used_next;
    logic [UW-1:0] idx_plus;
    logic [IW-1:0] wr_idx;
    logic wr_en;

    logic [CW-1:0] cnt_new;
    logic signed [SW:0] sum_wide;
    logic signed [SW-1:0] sum_new;

    logic div_done;
    logic signed [VW-1:0] div_q;

    logic out_valid_reg, out_valid_next;
    logic [LW-1:0] slot_reg;
    logic [AW-1:0] addr_out_reg;
    logic [CW-1:0] cnt_out_reg;
    logic signed [SW-1:0] sum_out_reg;
    logic signed [VW-1:0] avg_out_reg;
    logic is_new_reg;
    logic full_reg;
    logic last_reg;
    logic out_free;
    logic out_load;

    pss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_reg.sum),
        .divisor  (rd_reg.cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_in_reg <= s_tdata[15:0];
            delay_in_reg <= s_tdata[31:16];
            func_reg <= s_tuser;
        end
    end

    assign idx_plus = UW'(idx_reg + UW'(1));

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_init)
        begin
            idx_next = UW'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end
        used_next = used_reg;
        if (cmd.load_append)
        begin
            used_next = UW'(used_reg + UW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= UW'(1);
            used_reg <= UW'(1);
        end
        else
        begin
            idx_reg <= idx_next;
            used_reg <= used_next;
        end
    end

    // saturating update of a hit entry
    assign cnt_new = (rd_reg.cnt == '1) ? rd_reg.cnt : CW'(rd_reg.cnt + CW'(1));
    assign sum_wide = (SW+1)'(rd_reg.sum) + (SW+1)'(delay_in_reg);

    always_comb
    begin
        if (sum_wide[SW] != sum_wide[SW-1])
        begin
            sum_new = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sum_new = sum_wide[SW-1:0];
        end
    end

    assign wr_en = cmd.load_hit || cmd.load_append;
    assign wr_idx = cmd.load_append ? used_reg[IW-1:0] : idx_reg[IW-1:0];

    always_comb
    begin
        if (cmd.load_append)
        begin
            wr_data = '{addr: addr_in_reg, cnt: '0, sum: '0};
        end
        else
        begin
            wr_data = '{addr: rd_reg.addr, cnt: cnt_new, sum: sum_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[idx_reg[IW-1:0]];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = cmd.load_hit || cmd.load_append || cmd.load_full
                      || cmd.load_empty || cmd.load_report;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.load_hit)
        begin
            slot_reg <= LW'(idx_reg);
            addr_out_reg <= rd_reg.addr;
            cnt_out_reg <= cnt_new;
            sum_out_reg <= sum_new;
            avg_out_reg <= '0;
            is_new_reg <= 1'b0;
            full_reg <= 1'b0;
            last_reg <= 1'b1;
        end
        else if (cmd.load_append)
        begin
            slot_reg <= LW'(used_reg);
            addr_out_reg <= addr_in_reg;
            cnt_out_reg <= '0;
            sum_out_reg <= '0;
            avg_out_reg <= '0;
            is_new_reg <= 1'b1;
            full_reg <= 1'b0;
            last_reg <= 1'b1;
        end
        else if (cmd.load_full)
        begin
            slot_reg <= '0;
            addr_out_reg <= addr_in_reg;
            cnt_out_reg <= '0;
            sum_out_reg <= '0;
            avg_out_reg <= '0;
            is_new_reg <= 1'b0;
            full_reg <= 1'b1;
            last_reg <= 1'b1;
        end
        else if (cmd.load_empty)
        begin
            slot_reg <= '0;
            addr_out_reg <= '0;
            cnt_out_reg <= '0;
            sum_out_reg <= '0;
            avg_out_reg <= '0;
            is_new_reg <= 1'b0;
            full_reg <= 1'b0;
            last_reg <= 1'b1;
        end
        else if (cmd.load_report)
        begin
            slot_reg <= LW'(idx_reg);
            addr_out_reg <= rd_reg.addr;
            cnt_out_reg <= rd_reg.cnt;
            sum_out_reg <= rd_reg.sum;
            avg_out_reg <= div_q;
            is_new_reg <= 1'b0;
            full_reg <= 1'b0;
            last_reg <= (idx_plus == used_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, avg_out_reg, sum_out_reg, cnt_out_reg, addr_out_reg, slot_reg};
    assign m_tuser = {full_reg, is_new_reg};
    assign m_tlast = last_reg;

    assign sts.func = func_reg;
    assign sts.used_one = (used_reg == UW'(1));
    assign sts.is_full = (used_reg == UW'(TABLE_SLOTS));
    assign sts.hit = (rd_reg.addr == addr_in_reg);
    assign sts.idx_last = (idx_plus == used_reg);
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 && used_reg <= UW'(TABLE_SLOTS))
        else $error("slot fill count out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending result");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_append |-> used_reg < UW'(TABLE_SLOTS))
        else $error("append into a full table");

    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_append |=> m_tvalid && m_tuser[0] && cnt_out_reg == '0 && m_tlast)
        else $error("append result malformed");

endmodule
`default_nettype wire

FILE: rtl/pss_ctrl.sv
`default_nettype none
module pss_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire pss_pkg::sts_t sts,
    output pss_pkg::cmd_t cmd
);

    pss_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pss_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = pss_pkg::ST_DISPATCH;
                end
            end
            pss_pkg::ST_DISPATCH:
            begin
                if (sts.func == pss_pkg::FUNC_RECORD)
                begin
                    state_next = sts.used_one ? pss_pkg::ST_REC_END : pss_pkg::ST_SEARCH_RD;
                end
                else
                begin
                    state_next = sts.used_one ? pss_pkg::ST_EMPTY : pss_pkg::ST_REP_RD;
                end
            end
            pss_pkg::ST_SEARCH_RD:
            begin
                state_next = pss_pkg::ST_SEARCH_CMP;
            end
            pss_pkg::ST_SEARCH_CMP:
            begin
                priority if (sts.hit)
                begin
                    state_next = pss_pkg::ST_HIT;
                end
                else if (sts.idx_last)
                begin
                    state_next = pss_pkg::ST_REC_END;
                end
                else
                begin
                    state_next = pss_pkg::ST_SEARCH_RD;
                end
            end
            pss_pkg::ST_HIT, pss_pkg::ST_REC_END, pss_pkg::ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            pss_pkg::ST_REP_RD:
            begin
                state_next = pss_pkg::ST_REP_DIV;
            end
            pss_pkg::ST_REP_DIV:
            begin
                state_next = pss_pkg::ST_REP_WAIT;
            end
            pss_pkg::ST_REP_WAIT:
            begin
                if (sts.div_done && sts.out_free)
                begin
                    state_next = sts.idx_last ? pss_pkg::ST_IDLE : pss_pkg::ST_REP_RD;
                end
            end
            default:
            begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            pss_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.capture = s_tvalid;
                cmd.idx_init = s_tvalid;
            end
            pss_pkg::ST_SEARCH_RD, pss_pkg::ST_REP_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            pss_pkg::ST_SEARCH_CMP:
            begin
                // advance to the next used slot on a miss
                cmd.idx_inc = !sts.hit && !sts.idx_last;
            end
            pss_pkg::ST_HIT:
            begin
                cmd.load_hit = sts.out_free;
            end
            pss_pkg::ST_REC_END:
            begin
                cmd.load_append = sts.out_free && !sts.is_full;
                cmd.load_full = sts.out_free && sts.is_full;
            end
            pss_pkg::ST_EMPTY:
            begin
                cmd.load_empty = sts.out_free;
            end
            pss_pkg::ST_REP_DIV:
            begin
                cmd.div_start = 1'b1;
            end
            pss_pkg::ST_REP_WAIT:
            begin
                cmd.load_report = sts.div_done && sts.out_free;
                cmd.idx_inc = sts.div_done && sts.out_free && !sts.idx_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/per_source_packet_stats_table.sv
// Record item: used slots are read and compared in turn until a hit or the last slot, then
// the hit entry is updated, a new entry appended, or a table-full result given. Report item:
// per used slot, a table read, divider start, one-bit-per-cycle divider (32 steps), hand-off;
// an empty table answers with one empty result. A result waits in an output register, so
// the next item is taken while it is pending; a hand-off waits on a full one. One item at a time.
// Reset (rst_n, asynchronous, active low) empties the table, idles the controller, no clear.
`default_nettype none
module per_source_packet_stats_table #(
    parameter int TABLE_SLOTS = pss_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire logic [31:0] s_tdata,  // sender_addr[15:0], delay[31:16]
    input  wire logic s_tuser,         // func
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [87:0] m_tdata,       // slot_index[4:0], addr_out[20:5], packet_count[36:21],
                                       // delay_total[68:37], average_delay[84:69], zero pad
    output logic [1:0] m_tuser,        // is_new[0], table_full[1]
    output logic m_tlast
);

    pss_pkg::cmd_t cmd;
    pss_pkg::sts_t sts;

    pss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pss_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
